@@ rtl/core/scancode_to_ascii_decoder_core_assert.svh @@
// ----------------------------------------------------------------------------
// Scancode decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_DECODER_CORE_ASSERT_SVH
`define SCANCODE_TO_ASCII_DECODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SC2A_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scancode decoder check failed");

// Consequent must hold in the cycle after the antecedent.
`define SC2A_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scancode decoder check failed");

`endif

@@ rtl/core/sc2a_pkg.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder package
// Types, register indexes, key codes and the set 1 translation tables.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CTRL  = 2'd0,
    CFG_SHIFT = 2'd1,
    CFG_ALT   = 2'd2,
    CFG_CAPS  = 2'd3
  } cfg_idx_t;

  // Make codes of the four modifier keys.
  typedef struct packed {
    logic [6:0] ctrl_make;
    logic [6:0] shift_make;
    logic [6:0] alt_make;
    logic [6:0] caps_make;
  } cfg_t;

  // Modifier flags.
  typedef struct packed {
    logic ctrl;
    logic shift;
    logic alt;
    logic caps;
  } mods_t;

  // One decoded result.
  typedef struct packed {
    logic [6:0] key_code;
    logic [6:0] ascii_char;
    mods_t      mods;
  } res_t;

  localparam logic [6:0] CTRL_CODE_RST  = 7'd29;
  localparam logic [6:0] SHIFT_CODE_RST = 7'd42;
  localparam logic [6:0] ALT_CODE_RST   = 7'd56;
  localparam logic [6:0] CAPS_CODE_RST  = 7'd58;

  localparam logic [7:0] BACKSPACE_CODE = 8'h0E;

  localparam logic [6:0] CHAR_NONE   = 7'h00;
  localparam logic [6:0] CHAR_0      = 7'h30;
  localparam logic [6:0] CHAR_9      = 7'h39;
  localparam logic [6:0] CHAR_A_LO   = 7'h61;
  localparam logic [6:0] CHAR_Z_LO   = 7'h7A;
  localparam logic [6:0] CASE_OFFSET = 7'h20;

  // Unshifted character of a make code; CHAR_NONE for keys with no character.
  function automatic logic [6:0] base_char(input logic [6:0] code);
    logic [6:0] ch;
    begin
      case (code)
        7'h02: ch = 7'h31;  // 1
        7'h03: ch = 7'h32;
        7'h04: ch = 7'h33;
        7'h05: ch = 7'h34;
        7'h06: ch = 7'h35;
        7'h07: ch = 7'h36;
        7'h08: ch = 7'h37;
        7'h09: ch = 7'h38;
        7'h0A: ch = 7'h39;
        7'h0B: ch = 7'h30;  // 0
        7'h0C: ch = 7'h2D;  // -
        7'h0D: ch = 7'h3D;  // =
        7'h10: ch = 7'h71;  // q
        7'h11: ch = 7'h77;
        7'h12: ch = 7'h65;
        7'h13: ch = 7'h72;
        7'h14: ch = 7'h74;
        7'h15: ch = 7'h79;
        7'h16: ch = 7'h75;
        7'h17: ch = 7'h69;
        7'h18: ch = 7'h6F;
        7'h19: ch = 7'h70;  // p
        7'h1A: ch = 7'h5B;  // [
        7'h1B: ch = 7'h5D;  // ]
        7'h1C: ch = 7'h0A;  // newline
        7'h1E: ch = 7'h61;  // a
        7'h1F: ch = 7'h73;
        7'h20: ch = 7'h64;
        7'h21: ch = 7'h66;
        7'h22: ch = 7'h67;
        7'h23: ch = 7'h68;
        7'h24: ch = 7'h6A;
        7'h25: ch = 7'h6B;
        7'h26: ch = 7'h6C;  // l
        7'h27: ch = 7'h3B;  // ;
        7'h28: ch = 7'h27;  // apostrophe
        7'h29: ch = 7'h7E;  // ~
        7'h2C: ch = 7'h7A;  // z
        7'h2D: ch = 7'h78;
        7'h2E: ch = 7'h63;
        7'h2F: ch = 7'h76;
        7'h30: ch = 7'h62;
        7'h31: ch = 7'h6E;
        7'h32: ch = 7'h6D;  // m
        7'h33: ch = 7'h2C;  // ,
        7'h34: ch = 7'h2E;  // .
        7'h35: ch = 7'h2F;  // /
        7'h39: ch = 7'h20;  // space
        default: ch = CHAR_NONE;
      endcase
      return ch;
    end
  endfunction

  // Symbol above a digit key, indexed by the digit character.
  function automatic logic [6:0] digit_shift(input logic [6:0] ch);
    logic [6:0] sym;
    begin
      case (ch[3:0])
        4'd0: sym = 7'h29;  // )
        4'd1: sym = 7'h21;  // !
        4'd2: sym = 7'h40;  // @
        4'd3: sym = 7'h23;  // #
        4'd4: sym = 7'h24;  // $
        4'd5: sym = 7'h25;  // %
        4'd6: sym = 7'h5E;  // ^
        4'd7: sym = 7'h26;  // &
        4'd8: sym = 7'h2A;  // *
        4'd9: sym = 7'h28;  // (
        default: sym = ch;
      endcase
      return sym;
    end
  endfunction

endpackage

@@ rtl/core/sc2a_if.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder channel interfaces
// Valid/ready channels for scancode bytes in and decoded characters out.
// ----------------------------------------------------------------------------

// Scancode byte channel.
interface sc2a_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

// Decoded character channel.
interface sc2a_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] key_code;
  logic [6:0] ascii_char;
  logic       ctrl_held;
  logic       shift_held;
  logic       alt_held;
  logic       caps_on;

  modport source (output valid, output key_code, output ascii_char, output ctrl_held,
                  output shift_held, output alt_held, output caps_on, input ready);
  modport sink   (input valid, input key_code, input ascii_char, input ctrl_held,
                  input shift_held, input alt_held, input caps_on, output ready);
endinterface

@@ rtl/core/sc2a_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder configuration registers
// Holds the make codes of the four modifier keys, written by index.
// ----------------------------------------------------------------------------
module sc2a_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [6:0]       cfg_wdata,
  output sc2a_pkg::cfg_t   cfg
);

  sc2a_pkg::cfg_t cfg_r;
  sc2a_pkg::cfg_t cfg_nxt;

  // Select the register addressed by a write.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (sc2a_pkg::cfg_idx_t'(cfg_index))
        sc2a_pkg::CFG_CTRL:  cfg_nxt.ctrl_make  = cfg_wdata;
        sc2a_pkg::CFG_SHIFT: cfg_nxt.shift_make = cfg_wdata;
        sc2a_pkg::CFG_ALT:   cfg_nxt.alt_make   = cfg_wdata;
        sc2a_pkg::CFG_CAPS:  cfg_nxt.caps_make  = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ctrl_make  <= sc2a_pkg::CTRL_CODE_RST;
      cfg_r.shift_make <= sc2a_pkg::SHIFT_CODE_RST;
      cfg_r.alt_make   <= sc2a_pkg::ALT_CODE_RST;
      cfg_r.caps_make  <= sc2a_pkg::CAPS_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/sc2a_decode.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder translation stage
// Keeps the modifier flags and translates one registered scancode per cycle while step_en lets it move on.
// ----------------------------------------------------------------------------
module sc2a_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  sc2a_pkg::cfg_t   cfg,
  input  logic [7:0]       code,
  input  logic             step_en,
  output logic             has_result,
  output sc2a_pkg::res_t   result
);

  sc2a_pkg::mods_t flags_r;
  sc2a_pkg::mods_t flags_nxt;
  logic [6:0]      base;
  logic [6:0]      ch;

  // Table lookup with shift applied to digits and shift or caps to letters.
  always_comb begin
    base = sc2a_pkg::base_char(code[6:0]);
    ch   = base;
    if (base inside {[sc2a_pkg::CHAR_0:sc2a_pkg::CHAR_9]}) begin
      if (flags_r.shift) ch = sc2a_pkg::digit_shift(base);
    end else if (base inside {[sc2a_pkg::CHAR_A_LO:sc2a_pkg::CHAR_Z_LO]}) begin
      if (flags_r.shift || flags_r.caps) ch = base - sc2a_pkg::CASE_OFFSET;
    end
  end

  // Priority decode: backspace, modifier makes, modifier breaks, then keys.
  always_comb begin
    flags_nxt  = flags_r;
    has_result = 1'b0;
    if (code == sc2a_pkg::BACKSPACE_CODE) begin
      flags_nxt = flags_r;
    end else if (code == {1'b0, cfg.ctrl_make}) begin
      flags_nxt.ctrl = 1'b1;
    end else if (code == {1'b0, cfg.shift_make}) begin
      flags_nxt.shift = 1'b1;
    end else if (code == {1'b0, cfg.alt_make}) begin
      flags_nxt.alt = 1'b1;
    end else if (code == {1'b0, cfg.caps_make}) begin
      flags_nxt.caps = ~flags_r.caps;
    end else if (code == {1'b1, cfg.ctrl_make}) begin
      flags_nxt.ctrl = 1'b0;
    end else if (code == {1'b1, cfg.shift_make}) begin
      flags_nxt.shift = 1'b0;
    end else if (code == {1'b1, cfg.alt_make}) begin
      flags_nxt.alt = 1'b0;
    end else if (!code[7]) begin
      has_result = (base != sc2a_pkg::CHAR_NONE);
    end
  end

  // Flags advance only when the stage hands its item on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (step_en) begin
      flags_r <= flags_nxt;
    end
  end

  assign result.key_code   = code[6:0];
  assign result.ascii_char = ch;
  assign result.mods       = flags_r;

endmodule

@@ rtl/core/scancode_to_ascii_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Scancode set 1 to ASCII decoder
// Translates keyboard scancode bytes into characters with modifier state.
// ----------------------------------------------------------------------------
// The block takes one scancode byte per cycle while in_ch.ready is high and
// gives at most one character per byte, held first in the input register and
// then in the result register. Modifier keys, releases, backspace and unmapped
// codes update the flags or are dropped and produce no transfer on out_ch.
// Throughput is one byte per cycle, set by the combinational table lookup and
// flag update; it drops only while out_ch.ready holds back a pending result.
// The modifier make codes are written through cfg_we, cfg_index and cfg_wdata;
// users must write them only while no byte is in flight; the block leaves that to them.
module scancode_to_ascii_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  sc2a_in_if.sink     in_ch,
  sc2a_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);

  `include "scancode_to_ascii_decoder_core_assert.svh"

  sc2a_pkg::cfg_t cfg;
  sc2a_pkg::res_t dec_result;
  logic           dec_has_result;

  logic           s1_valid_r;
  logic           s1_valid_nxt;
  logic [7:0]     s1_byte_r;
  logic           out_valid_r;
  logic           out_valid_nxt;
  sc2a_pkg::res_t out_res_r;
  logic           step_en;
  logic           in_xfer;

  // Modifier code registers.
  sc2a_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Translation and modifier flags.
  sc2a_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .code       (s1_byte_r),
    .step_en    (step_en),
    .has_result (dec_has_result),
    .result     (dec_result)
  );

  // The input stage moves on unless its result finds the output still full.
  assign step_en     = s1_valid_r && (!dec_has_result || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || step_en;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.ready) s1_valid_nxt = in_ch.valid;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en && dec_has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) s1_byte_r <= in_ch.scan_byte;
    if (step_en && dec_has_result) out_res_r <= dec_result;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.key_code   = out_res_r.key_code;
  assign out_ch.ascii_char = out_res_r.ascii_char;
  assign out_ch.ctrl_held  = out_res_r.mods.ctrl;
  assign out_ch.shift_held = out_res_r.mods.shift;
  assign out_ch.alt_held   = out_res_r.mods.alt;
  assign out_ch.caps_on    = out_res_r.mods.caps;

  // Releases and backspace never produce a character.
  `SC2A_ASSERT_SAME(a_release_no_char, s1_valid_r && s1_byte_r[7], !dec_has_result)
  `SC2A_ASSERT_SAME(a_bksp, s1_valid_r && (s1_byte_r == sc2a_pkg::BACKSPACE_CODE), !dec_has_result)
  // A decoded character is presented in the next cycle.
  `SC2A_ASSERT_NEXT(a_char_loaded, step_en && dec_has_result, out_valid_r)
  // A held input item keeps its byte until it moves on.
  `SC2A_ASSERT_NEXT(a_s1_hold, s1_valid_r && !step_en, s1_valid_r && $stable(s1_byte_r))

endmodule

@@ test/scancode_to_ascii_decoder_core_test.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder core testbench
// Sends set 1 scancode bytes into the decoder under several modifier key
// settings and idle patterns, predicts each character and its modifier
// snapshot, and checks every transfer on the result channel in order.
// ----------------------------------------------------------------------------
module scancode_to_ascii_decoder_core_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int HOLD_SPACING = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we;
  sc2a_pkg::cfg_idx_t   cfg_index;
  logic [6:0]           cfg_wdata;

  sc2a_in_if  in_ch ();
  sc2a_out_if out_ch ();

  scancode_to_ascii_decoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Translation tables of the predictor, filled at time zero.
  logic [6:0] key_char [128];
  logic [6:0] digit_sym [10];

  // Predictor state: modifier make codes and modifier flags.
  sc2a_pkg::cfg_t  key_cfg;
  sc2a_pkg::mods_t mod_state;

  logic [7:0]     pending_scans [$];
  sc2a_pkg::res_t due_chars [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  in_took;
  int  cycle_count;
  int  scans_taken;
  int  chars_seen;
  int  bad_count;
  int  settings_used;
  int  hold_left;
  int  next_hold = 120;

  // Free-running clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode one accepted scancode into the character it yields, if any.
  task automatic decode_scan(input logic [7:0] code, output bit produced,
                             output sc2a_pkg::res_t r);
    logic [6:0] base;
    logic [6:0] ch;
    produced = 1'b0;
    r = '0;
    base = key_char[code[6:0]];
    if (code == sc2a_pkg::BACKSPACE_CODE) begin
      // Backspace is dropped before any modifier compare.
    end else if (code == {1'b0, key_cfg.ctrl_make}) begin
      mod_state.ctrl = 1'b1;
    end else if (code == {1'b0, key_cfg.shift_make}) begin
      mod_state.shift = 1'b1;
    end else if (code == {1'b0, key_cfg.alt_make}) begin
      mod_state.alt = 1'b1;
    end else if (code == {1'b0, key_cfg.caps_make}) begin
      mod_state.caps = ~mod_state.caps;
    end else if (code == {1'b1, key_cfg.ctrl_make}) begin
      mod_state.ctrl = 1'b0;
    end else if (code == {1'b1, key_cfg.shift_make}) begin
      mod_state.shift = 1'b0;
    end else if (code == {1'b1, key_cfg.alt_make}) begin
      mod_state.alt = 1'b0;
    end else if (!code[7] && base != sc2a_pkg::CHAR_NONE) begin
      ch = base;
      if (base >= sc2a_pkg::CHAR_0 && base <= sc2a_pkg::CHAR_9) begin
        if (mod_state.shift) ch = digit_sym[base - sc2a_pkg::CHAR_0];
      end else if (base >= sc2a_pkg::CHAR_A_LO && base <= sc2a_pkg::CHAR_Z_LO) begin
        if (mod_state.shift || mod_state.caps) ch = base - sc2a_pkg::CASE_OFFSET;
      end
      r.key_code   = code[6:0];
      r.ascii_char = ch;
      r.mods       = mod_state;
      produced     = 1'b1;
    end
  endtask

  // Make code of one of the four modifiers under the current setting.
  function automatic logic [6:0] modifier_code(input int which);
    case (which)
      0: return key_cfg.ctrl_make;
      1: return key_cfg.shift_make;
      2: return key_cfg.alt_make;
      default: return key_cfg.caps_make;
    endcase
  endfunction

  // Random scancode shaped like real typing, with some raw noise mixed in.
  function automatic logic [7:0] pick_scan();
    int unsigned roll;
    logic [6:0] k;
    roll = $urandom_range(99);
    if (roll < 50) begin
      do k = 7'($urandom_range(7'h39, 7'h02)); while (key_char[k] == sc2a_pkg::CHAR_NONE);
      return {roll >= 40, k};
    end else if (roll < 80) begin
      return {$urandom_range(9) < 3, modifier_code($urandom_range(3))};
    end
    return 8'($urandom);
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      bad_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Acceptance, prediction and result checking at the rising edge.
  always @(posedge clk) begin
    sc2a_pkg::res_t want;
    sc2a_pkg::res_t fresh;
    bit             produced;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d characters outstanding", $time, due_chars.size());
        $display("end of test: mismatches");
        $finish;
      end else begin
        in_took = in_ch.valid && in_ch.ready;
        if (in_took) begin
          void'(pending_scans.pop_front());
          scans_taken++;
          decode_scan(in_ch.scan_byte, produced, fresh);
          if (produced) due_chars.push_back(fresh);
        end
        if (out_ch.valid && out_ch.ready) begin
          chars_seen++;
          if (due_chars.size() == 0) begin
            bad_count++;
            $display("%0t: unexpected transfer, key_code %0h ascii_char %0h",
                     $time, out_ch.key_code, out_ch.ascii_char);
          end else begin
            want = due_chars.pop_front();
            check_field("key_code", want.key_code, out_ch.key_code);
            check_field("ascii_char", want.ascii_char, out_ch.ascii_char);
            check_field("ctrl_held", want.mods.ctrl, out_ch.ctrl_held);
            check_field("shift_held", want.mods.shift, out_ch.shift_held);
            check_field("alt_held", want.mods.alt, out_ch.alt_held);
            check_field("caps_on", want.mods.caps, out_ch.caps_on);
          end
        end
      end
    end
  end

  // Scancode driver: holds an offer until it transfers, idles at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (pending_scans.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid     <= 1'b1;
        in_ch.scan_byte <= pending_scans[0];
      end else begin
        in_ch.valid     <= 1'b0;
        in_ch.scan_byte <= 8'($urandom);
      end
    end
  end

  // Result receiver: random stalls plus a long hold-off now and then.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (chars_seen >= next_hold) begin
      hold_left = HOLD_CYCLES;
      next_hold += HOLD_SPACING;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Wait until every queued byte has transferred and every character arrived.
  task automatic drain();
    @(negedge clk);
    while (pending_scans.size() != 0 || due_chars.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input sc2a_pkg::cfg_idx_t idx, input logic [6:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      sc2a_pkg::CFG_CTRL:  key_cfg.ctrl_make  = val;
      sc2a_pkg::CFG_SHIFT: key_cfg.shift_make = val;
      sc2a_pkg::CFG_ALT:   key_cfg.alt_make   = val;
      sc2a_pkg::CFG_CAPS:  key_cfg.caps_make  = val;
      default:             key_cfg = key_cfg;
    endcase
  endtask

  task automatic set_keys(input logic [6:0] c, input logic [6:0] s,
                          input logic [6:0] a, input logic [6:0] k);
    write_reg(sc2a_pkg::CFG_CTRL, c);
    write_reg(sc2a_pkg::CFG_SHIFT, s);
    write_reg(sc2a_pkg::CFG_ALT, a);
    write_reg(sc2a_pkg::CFG_CAPS, k);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_batch(input int n);
    repeat (n) pending_scans.push_back(pick_scan());
    drain();
  endtask

  initial begin
    string      rows [4];
    logic [7:0] row_start [4];
    string      syms;
    byte        c;
    logic [7:0] opening [22];
    logic [7:0] odd_keys [7];

    // Build the set 1 character table.
    rows      = '{"1234567890-=", "qwertyuiop[]", "asdfghjkl;'~", "zxcvbnm,./"};
    row_start = '{8'h02, 8'h10, 8'h1E, 8'h2C};
    syms      = ")!@#$%^&*(";
    for (int i = 0; i < 128; i++) key_char[i] = sc2a_pkg::CHAR_NONE;
    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < rows[r].len(); i++) begin
        c = rows[r][i];
        key_char[row_start[r] + i] = c[6:0];
      end
    end
    key_char[7'h1C] = 7'h0A;
    key_char[7'h39] = 7'h20;
    for (int i = 0; i < 10; i++) begin
      c = syms[i];
      digit_sym[i] = c[6:0];
    end

    in_ch.valid     = 1'b0;
    in_ch.scan_byte = 8'h00;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = sc2a_pkg::CFG_CTRL;
    cfg_wdata       = 7'h00;
    key_cfg   = '{sc2a_pkg::CTRL_CODE_RST, sc2a_pkg::SHIFT_CODE_RST,
                  sc2a_pkg::ALT_CODE_RST, sc2a_pkg::CAPS_CODE_RST};
    mod_state = '0;
    settings_used = 1;
    send_idle_pct = 17;
    recv_idle_pct = 77;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset key setting: edges of the byte range, each modifier, caps on and
    // off, shifted digits and letters, symbols that ignore shift.
    opening = '{8'h00, 8'h02, 8'h2A, 8'h02, 8'h0D, 8'h28, 8'h10, 8'hAA,
                8'h3A, 8'h1E, 8'h0B, 8'h3A, 8'hBA, 8'h1D, 8'h38, 8'h39,
                8'h1C, 8'h9D, 8'hB8, 8'h0E, 8'hFF, 8'h7F};
    foreach (opening[i]) pending_scans.push_back(opening[i]);
    drain();

    // Extreme codes, alt on the backspace code, caps lock on the 'a' key.
    set_keys(7'h00, 7'h7F, 7'h0E, 7'h1E);
    odd_keys = '{8'h0E, 8'h00, 8'h7F, 8'h1E, 8'h02, 8'h20, 8'hFF};
    foreach (odd_keys[i]) pending_scans.push_back(odd_keys[i]);
    run_batch(190);

    // Ctrl and shift share one code, so shift never acts.
    set_keys(7'h10, 7'h10, 7'h7F, 7'h00);
    run_batch(200);

    // Reset codes again, with the idle pattern reversed; the sender also
    // pauses midway until every character has come back.
    send_idle_pct = 77;
    recv_idle_pct = 17;
    set_keys(sc2a_pkg::CTRL_CODE_RST, sc2a_pkg::SHIFT_CODE_RST,
             sc2a_pkg::ALT_CODE_RST, sc2a_pkg::CAPS_CODE_RST);
    run_batch(150);
    run_batch(150);

    set_keys(7'($urandom_range(127)), 7'($urandom_range(127)),
             7'($urandom_range(127)), 7'($urandom_range(127)));
    run_batch(200);

    // No random idling on either side; the receiver's long hold-offs still occur.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_keys(sc2a_pkg::CTRL_CODE_RST, sc2a_pkg::SHIFT_CODE_RST,
             sc2a_pkg::ALT_CODE_RST, sc2a_pkg::CAPS_CODE_RST);
    run_batch(225);

    $display("Sent %0d scancodes and checked %0d characters under %0d key settings,",
             scans_taken, chars_seen, settings_used);
    $display("with both idle patterns, a no-idle stretch and long receiver hold-offs.");
    if (bad_count == 0 && due_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sc2a_pkg.sv
rtl/core/sc2a_if.sv
rtl/core/sc2a_cfg_regs.sv
rtl/core/sc2a_decode.sv
rtl/core/scancode_to_ascii_decoder_core.sv
test/scancode_to_ascii_decoder_core_test.sv
